// File: hdl/tmac_pkg.sv
// Shared types and constants for the trimmed-mean ADC calibrator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tmac_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SUM_W       = 16;
   localparam int SEEN_W      = 4;
   localparam int GAIN_W      = 24;
   localparam int OFFSET_W    = 16;
   localparam int OUT_W       = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET = 8'd1;

   localparam logic [GAIN_W-1:0]          GAIN_RESET   = 24'd634820;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -16'sd22;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
   localparam logic [OUT_W-1:0]    OUT_MAX    = {OUT_W{1'b1}};

   typedef struct packed {
      logic [GAIN_W-1:0]          gain;
      logic signed [OFFSET_W-1:0] offset;
   } tmac_cal_type;

endpackage

`default_nettype wire

// File: hdl/trimmed_mean_adc_calibrator_top.sv
// Trimmed-mean ADC calibrator, top level: calibration registers and the
// front, queue and back parts. Uses tmac_pkg, tmac_front, tmac_queue, tmac_back.
// Throughput: one sample per cycle, limited by the front accumulator loop; none while
// the queue is full. A window's result passes through s1, s2, s3 and out to rsp_valid.
// Reset: synchronous, clears the window, the queue and the pipeline and
// loads the default gain and offset; no clearing pass.
`default_nettype none

module trimmed_mean_adc_calibrator_top import tmac_pkg::*; #(
   parameter int WINDOW      = 10,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [OUT_W-1:0]            rsp_average_mv,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [GAIN_W-1:0]          gain_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   tmac_cal_type               cal;
   logic                       push_valid, push_ready, pop_valid, pop_ready;
   logic [SUM_W-1:0]           push_trim, pop_trim;

   assign csr_ready  = 1'b1;
   assign cal.gain   = gain_ff;
   assign cal.offset = offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_GAIN) begin
            gain_ff <= csr_wdata[GAIN_W-1:0];
         end else if (csr_index == CSR_OFFSET) begin
            offset_ff <= csr_wdata[OFFSET_W-1:0];
         end
      end
   end

   tmac_front #(.WINDOW(WINDOW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_trim  (push_trim)
   );

   tmac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_trim  (push_trim),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_trim   (pop_trim)
   );

   tmac_back #(.WINDOW(WINDOW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (pop_valid),
      .q_ready        (pop_ready),
      .q_trim         (pop_trim),
      .cal            (cal),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_average_mv (rsp_average_mv)
   );

endmodule

`default_nettype wire

// File: hdl/tmac_front.sv
// Front part: accepts samples, tracks window sum, minimum and maximum,
// and pushes the trimmed sum into the queue when a window closes. Uses tmac_pkg.
`default_nettype none

module tmac_front import tmac_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output logic [SUM_W-1:0]         push_trim
);

   localparam logic [SEEN_W:0] WIN_L = (SEEN_W + 1)'(WINDOW);

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [SUM_W-1:0]    sum_next;
   logic [SAMPLE_W-1:0] lo, hi;
   logic                accept, close;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      sum_next = sum_ff + SUM_W'(req_sample);
      lo       = (req_sample < min_ff) ? req_sample : min_ff;
      hi       = (req_sample > max_ff) ? req_sample : max_ff;
      close    = ({1'b0, seen_ff} + (SEEN_W + 1)'(1)) >= WIN_L;
      push_valid = accept && close;
      push_trim  = sum_next - SUM_W'(lo) - SUM_W'(hi);
   end

   always_comb begin
      sum_in  = sum_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (close) begin
            sum_in  = '0;
            min_in  = SAMPLE_MAX;
            max_in  = '0;
            seen_in = '0;
         end else begin
            sum_in  = sum_next;
            min_in  = lo;
            max_in  = hi;
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         min_ff  <= SAMPLE_MAX;
         max_ff  <= '0;
         seen_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tmac_queue.sv
// Short queue of trimmed sums between the front and back parts.
// Uses tmac_pkg for the item width.
`default_nettype none

module tmac_queue import tmac_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [SUM_W-1:0] push_trim,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [SUM_W-1:0]      pop_trim
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   logic [SUM_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != FULL);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_trim   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_trim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL)
      else $error("queue count past depth");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty with pointers apart");

endmodule

`default_nettype wire

// File: hdl/tmac_back.sv
// Back part: calibration pipeline with gain multiply, offset and rounding,
// division by the trimmed count through a reciprocal, and saturation. Uses tmac_pkg.
`default_nettype none

module tmac_back import tmac_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  q_ready,
   input  wire logic [SUM_W-1:0] q_trim,
   input  wire tmac_cal_type     cal,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [OUT_W-1:0]      rsp_average_mv
);

   localparam int D     = WINDOW - 2;
   localparam int TW    = $clog2(65536 * D);
   localparam int RS    = TW + $clog2(D);
   localparam int PW    = TW + RS + 1;
   localparam int MW    = GAIN_W + SUM_W;
   localparam int NUM_W = MW + 2;
   localparam int TF_W  = NUM_W - 16;
   localparam logic [63:0] RECIP64 = ((64'd1 << RS) + 64'(D) - 64'd1) / 64'(D);
   localparam logic [PW-1:0] RECIP = PW'(RECIP64);
   localparam logic signed [NUM_W-1:0] HALF = NUM_W'(32768 * D);
   localparam logic signed [NUM_W-1:0] DEN_S = NUM_W'(D);
   localparam logic [TF_W-1:0] TLIM = TF_W'(65536 * D);

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [MW-1:0]     s1_prod_ff;
   logic [TW-1:0]     s2_t_ff;
   logic              s2_neg_ff, s2_sat_ff;
   logic [PW-1:0]     s3_prod_ff;
   logic              s3_neg_ff, s3_sat_ff;
   logic [OUT_W-1:0]  out_data_ff;

   logic out_free, s3_free, s2_free, s1_free;
   logic signed [NUM_W-1:0] num, off_x, off_scaled;
   logic [TF_W-1:0]   t_full;
   logic              neg, sat;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign q_ready  = s1_free;

   assign rsp_valid      = out_valid_ff;
   assign rsp_average_mv = out_data_ff;

   always_comb begin
      off_x      = NUM_W'(cal.offset);
      off_scaled = (off_x * DEN_S) <<< 16;
      num        = $signed({2'b00, s1_prod_ff}) + off_scaled + HALF;
      neg        = num[NUM_W-1];
      t_full     = num[NUM_W-1:16];
      sat        = !neg && (t_full >= TLIM);
   end

   always_ff @(posedge clock) begin
      if (s1_free && q_valid) begin
         s1_prod_ff <= MW'(q_trim) * MW'(cal.gain);
      end
      if (s2_free && s1_valid_ff) begin
         s2_t_ff   <= t_full[TW-1:0];
         s2_neg_ff <= neg;
         s2_sat_ff <= sat;
      end
      if (s3_free && s2_valid_ff) begin
         s3_prod_ff <= PW'(s2_t_ff) * RECIP;
         s3_neg_ff  <= s2_neg_ff;
         s3_sat_ff  <= s2_sat_ff;
      end
      if (out_free && s3_valid_ff) begin
         if (s3_neg_ff) begin
            out_data_ff <= '0;
         end else if (s3_sat_ff) begin
            out_data_ff <= OUT_MAX;
         end else begin
            out_data_ff <= s3_prod_ff[RS +: OUT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= q_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   a_neg_sat_excl : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> !(s3_neg_ff && s3_sat_ff))
      else $error("negative and saturated both set");

   a_s3_hold : assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && out_valid_ff && !rsp_ready) |=> s3_valid_ff)
      else $error("stage three item lost under stall");

endmodule

`default_nettype wire

// File: tb/tb_trimmed_mean_adc_calibrator_top.sv
// Testbench for trimmed_mean_adc_calibrator_top: streams ADC samples, predicts each
// window's calibrated trimmed mean and checks every result item in order.
// Depends on tmac_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_trimmed_mean_adc_calibrator_top;
   import tmac_pkg::*;

   localparam int WINDOW      = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_PRINTS  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 8'hFF;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [OUT_W-1:0]       rsp_average_mv;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [GAIN_W-1:0]          cal_gain;
   logic signed [OFFSET_W-1:0] cal_offset;
   logic [SUM_W-1:0]           win_sum;
   logic [SAMPLE_W-1:0]        win_min;
   logic [SAMPLE_W-1:0]        win_max;
   logic [SEEN_W-1:0]          win_count;
   logic [OUT_W-1:0]           expected_mv_q[$];

   int send_idle_pct;
   int stall_pct;
   int hold_left;
   int error_count;
   int cycle_count;
   int samples_sent;
   int windows_checked;
   int csr_writes;

   trimmed_mean_adc_calibrator_top #(
      .WINDOW(WINDOW)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average_mv(rsp_average_mv),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [OUT_W-1:0] calibrated_mv(input logic [SUM_W-1:0] trim);
      longint den;
      longint num;
      longint q;
      den = 64'sd65536 * (WINDOW - 2);
      num = longint'(trim) * longint'(cal_gain) + longint'(cal_offset) * den + den / 2;
      if (num < 0) begin
         return '0;
      end
      q = num / den;
      if (q > longint'(OUT_MAX)) begin
         q = longint'(OUT_MAX);
      end
      return q[OUT_W-1:0];
   endfunction

   task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      sum = win_sum + SUM_W'(s);
      lo  = (s < win_min) ? s : win_min;
      hi  = (s > win_max) ? s : win_max;
      if (win_count + 1 < WINDOW) begin
         win_sum   = sum;
         win_min   = lo;
         win_max   = hi;
         win_count = win_count + SEEN_W'(1);
      end else begin
         expected_mv_q.push_back(calibrated_mv(sum - SUM_W'(lo) - SUM_W'(hi)));
         win_sum   = '0;
         win_min   = SAMPLE_MAX;
         win_max   = '0;
         win_count = '0;
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) begin
         $display("MISMATCH @%0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_sample(s);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_mv_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_GAIN) begin
         cal_gain = data[GAIN_W-1:0];
      end else if (idx == CSR_OFFSET) begin
         cal_offset = data[OFFSET_W-1:0];
      end
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_calibration(input logic [GAIN_W-1:0] gain,
                                  input logic [OFFSET_W-1:0] offset);
      logic [CSR_DATA_W-1:0] offset_word;
      wait_idle();
      offset_word = {8'($urandom_range(255)), offset};
      if ($urandom_range(1)) begin
         write_register(CSR_GAIN, gain);
         write_register(CSR_OFFSET, offset_word);
      end else begin
         write_register(CSR_OFFSET, offset_word);
         write_register(CSR_GAIN, gain);
      end
      if ($urandom_range(3) == 0) begin
         write_register(8'($urandom_range(255, 2)), 24'($urandom));
      end
   endtask

   task automatic test_reset_calibration();
      logic [SAMPLE_W-1:0] s;
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int i = 0; i < WINDOW; i++) begin
         case (i)
            0:       s = '0;
            1:       s = SAMPLE_MAX;
            2:       s = 12'h555;
            3:       s = 12'hAAA;
            default: s = 12'd2000;
         endcase
         send_sample(s);
      end
      wait_idle();
   endtask

   task automatic test_saturation_high();
      set_calibration({GAIN_W{1'b1}}, 16'h7FFF);
      for (int i = 0; i < WINDOW; i++) begin
         send_sample(SAMPLE_MAX);
      end
      wait_idle();
   endtask

   task automatic test_rounding_half_up();
      set_calibration(24'd32768, 16'd0);
      write_register(CSR_UNMAPPED, {CSR_DATA_W{1'b1}});
      send_idle_pct = 12;
      stall_pct     = 12;
      for (int i = 0; i < WINDOW; i++) begin
         send_sample((i == 0) ? 12'd0 : (i == WINDOW - 1) ? 12'd2 : 12'd1);
      end
      wait_idle();
   endtask

   task automatic run_random_phase(input int n, input int idle_pct, input int stall);
      logic [SAMPLE_W-1:0] base;
      int v;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      base          = 12'($urandom_range(4095));
      for (int i = 0; i < n; i++) begin
         if (win_count == 0) begin
            base = 12'($urandom_range(4095));
         end
         case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(4095);
            8:          v = $urandom_range(1) ? 4095 : 0;
            9:          v = base;
            default:    v = int'(base) + int'($urandom_range(127)) - 64;
         endcase
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         send_sample(12'(v));
      end
   endtask

   task automatic test_random_traffic();
      logic [GAIN_W-1:0]   gain;
      logic [OFFSET_W-1:0] offset;
      int idle_mode[4];
      int stall_mode[4];
      idle_mode  = '{0, 52, 0, 12};
      stall_mode = '{0, 0, 52, 12};
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               gain   = GAIN_RESET;
               offset = OFFSET_RESET;
            end
            1: begin
               gain   = {GAIN_W{1'b1}};
               offset = 16'h7FFF;
            end
            2: begin
               gain   = '0;
               offset = 16'h8000;
            end
            default: begin
               gain   = ($urandom_range(3) == 0) ? 24'($urandom_range(16777215))
                                                 : 24'($urandom_range(1200000));
               offset = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(4096)) - 16'd2048;
            end
         endcase
         set_calibration(gain, offset);
         run_random_phase(200, idle_mode[p % 4], stall_mode[p % 4]);
      end
      wait_idle();
   endtask

   task automatic test_queue_backpressure();
      wait_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 400;
      for (int i = 0; i < 150; i++) begin
         send_sample(12'($urandom_range(4095)));
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mv_q.size() == 0) begin
            report_mismatch($sformatf("unexpected average_mv %0d", rsp_average_mv));
         end else begin
            if (rsp_average_mv !== expected_mv_q[0]) begin
               report_mismatch($sformatf("average_mv %0d, want %0d",
                                         rsp_average_mv, expected_mv_q[0]));
            end
            void'(expected_mv_q.pop_front());
            windows_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("trimmed_mean_adc_calibrator_top test failed");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample      = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      hold_left       = 0;
      error_count     = 0;
      cycle_count     = 0;
      samples_sent    = 0;
      windows_checked = 0;
      csr_writes      = 0;
      cal_gain        = GAIN_RESET;
      cal_offset      = OFFSET_RESET;
      win_sum         = '0;
      win_min         = SAMPLE_MAX;
      win_max         = '0;
      win_count       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_calibration();
      test_saturation_high();
      test_rounding_half_up();
      test_random_traffic();
      test_queue_backpressure();

      wait_idle();
      $display("Covered %0d samples and %0d windows over %0d register writes,",
               samples_sent, windows_checked, csr_writes);
      $display("with saturation, rounding, idle/stall mixes and a full-queue stall.");
      if (error_count == 0) begin
         $display("trimmed_mean_adc_calibrator_top test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("trimmed_mean_adc_calibrator_top test failed");
      end
      $finish;
   end

endmodule

// File: trimmed_mean_adc_calibrator_top.f
hdl/tmac_pkg.sv
hdl/tmac_front.sv
hdl/tmac_queue.sv
hdl/tmac_back.sv
hdl/trimmed_mean_adc_calibrator_top.sv
tb/tb_trimmed_mean_adc_calibrator_top.sv
